// File: design/pidpd_pkg.sv
// Shared types, register indexes and fixed-point helpers for the PID regulator.
`default_nettype none

package pidpd_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned LIMIT_W = 31;
    localparam int unsigned INDEX_W = 3;
    localparam int unsigned WIDE_W  = 50;

    // Configuration register indexes
    localparam logic [INDEX_W-1:0] REG_ALGORITHM_FORM = 3'd0;
    localparam logic [INDEX_W-1:0] REG_GAIN_P         = 3'd1;
    localparam logic [INDEX_W-1:0] REG_GAIN_I         = 3'd2;
    localparam logic [INDEX_W-1:0] REG_GAIN_D         = 3'd3;
    localparam logic [INDEX_W-1:0] REG_OUTPUT_LIMIT   = 3'd4;
    localparam logic [INDEX_W-1:0] REG_INTEGRAL_LIMIT = 3'd5;

    // Algorithm form codes
    localparam logic FORM_POSITIONAL  = 1'b0;
    localparam logic FORM_INCREMENTAL = 1'b1;

    typedef struct packed {
        logic                      algorithm_form;
        logic signed [WORD_W-1:0]  gain_p;
        logic signed [WORD_W-1:0]  gain_i;
        logic signed [WORD_W-1:0]  gain_d;
        logic        [LIMIT_W-1:0] output_limit;
        logic        [LIMIT_W-1:0] integral_limit;
    } pidpd_cfg_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] error_now;
        logic signed [WORD_W-1:0] error_last;
        logic signed [WORD_W-1:0] error_before_last;
        logic signed [WORD_W-1:0] integral_sum;
        logic signed [WORD_W-1:0] output_held;
    } pidpd_state_t;

    // Saturate a wide signed value to one word
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] max_v;
        logic signed [WIDE_W-1:0] min_v;
        max_v = {{(WIDE_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
        min_v = {{(WIDE_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};
        if (x > max_v)
        begin
            return max_v[WORD_W-1:0];
        end
        else if (x < min_v)
        begin
            return min_v[WORD_W-1:0];
        end
        return x[WORD_W-1:0];
    endfunction

    // Q16.16 product: full product, drop 16 fraction bits toward zero, saturate
    function automatic logic signed [WORD_W-1:0] q_mul(input logic signed [WORD_W-1:0] a,
                                                       input logic signed [WORD_W-1:0] b);
        logic signed [2*WORD_W-1:0] prod;
        logic signed [2*WORD_W-17:0] quo;
        prod = a * b;
        quo  = prod[2*WORD_W-1:16];
        if (prod[2*WORD_W-1] && (|prod[15:0]))
        begin
            quo = quo + 48'sd1;
        end
        return sat_word({{(WIDE_W-2*WORD_W+16){quo[2*WORD_W-17]}}, quo});
    endfunction

    // Symmetric clamp to plus or minus an unsigned magnitude
    function automatic logic signed [WORD_W-1:0] clamp_sym(input logic signed [WORD_W-1:0] x,
                                                           input logic [LIMIT_W-1:0] lim);
        logic signed [WORD_W:0] xe;
        logic signed [WORD_W:0] pos;
        logic signed [WORD_W:0] neg;
        xe  = {x[WORD_W-1], x};
        pos = {2'b00, lim};
        neg = -pos;
        if (xe > pos)
        begin
            return pos[WORD_W-1:0];
        end
        else if (xe < neg)
        begin
            return neg[WORD_W-1:0];
        end
        return x;
    endfunction

endpackage

`default_nettype wire

// File: design/pid_position_delta_regulator.sv
// Top level of the PID regulator: stream handshake, registers and result stage.
//
// Usage:
//   s_* carries one beat per control sample: setpoint and measured value.
//   m_* returns one beat per sample: the clamped drive value.
//   cfg_* writes the six control registers (form, three gains, two limits);
//   cfg_ready is always high. Write only while no sample is in flight.
// Timing:
//   A sample accepted into the input register is evaluated by the whole
//   combinational control law, and its drive is loaded into the result
//   register when that register can advance; m_tvalid is its valid flag.
//   One beat per cycle is sustained while m_tready stays high; the error
//   history, integral and held output update in the same edge that loads
//   the result register, so the next sample sees them directly.
// Reset:
//   rst_n clears the valid flags, gains, limits and history to zero.
// Backpressure:
//   While m_tready is low the result register holds, the input register
//   holds its sample, and s_tready drops once both are full.
`default_nettype none

module pid_position_delta_regulator
(
    input  logic                               clk,
    input  logic                               rst_n,
    // Input beat
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [2*pidpd_pkg::WORD_W-1:0]     s_tdata,   // [31:0] setpoint, [63:32] measured
    // Result beat
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pidpd_pkg::WORD_W-1:0]       m_tdata,   // [31:0] drive
    // Register writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pidpd_pkg::INDEX_W-1:0]      cfg_index,
    input  logic [pidpd_pkg::WORD_W-1:0]       cfg_data
);
    import pidpd_pkg::*;

    pidpd_cfg_t               cfg_reg;
    pidpd_state_t             state_reg;
    pidpd_state_t             state_next;
    logic                     stage_valid_reg;
    logic signed [WORD_W-1:0] setpoint_reg;
    logic signed [WORD_W-1:0] measured_reg;
    logic                     out_valid_reg;
    logic signed [WORD_W-1:0] drive_reg;
    logic signed [WORD_W-1:0] drive_next;
    logic                     advance;
    logic                     load_result;

    // Result stage can take a new value when empty or draining this cycle
    assign advance     = !out_valid_reg || m_tready;
    assign load_result = stage_valid_reg && advance;
    assign s_tready    = !stage_valid_reg || advance;
    assign cfg_ready   = 1'b1;
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = drive_reg;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ALGORITHM_FORM: cfg_reg.algorithm_form <= cfg_data[0];
                REG_GAIN_P:         cfg_reg.gain_p         <= cfg_data;
                REG_GAIN_I:         cfg_reg.gain_i         <= cfg_data;
                REG_GAIN_D:         cfg_reg.gain_d         <= cfg_data;
                REG_OUTPUT_LIMIT:   cfg_reg.output_limit   <= cfg_data[LIMIT_W-1:0];
                REG_INTEGRAL_LIMIT: cfg_reg.integral_limit <= cfg_data[LIMIT_W-1:0];
                default:            cfg_reg <= cfg_reg;   // unmapped index: drop
            endcase
        end
    end

    // Input register: hold the sample until the result stage takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            stage_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            setpoint_reg <= s_tdata[WORD_W-1:0];
            measured_reg <= s_tdata[2*WORD_W-1:WORD_W];
        end
    end

    pidpd_datapath u_datapath
    (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .setpoint   (setpoint_reg),
        .measured   (measured_reg),
        .state_next (state_next),
        .drive      (drive_next)
    );

    // Controller state advances exactly once per delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (load_result)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            drive_reg <= drive_next;
        end
    end

    // Held output always mirrors the last delivered drive value
    assert property (@(posedge clk) disable iff (!rst_n)
        load_result |=> (state_reg.output_held == drive_reg))
        else $error("held output differs from loaded drive");

    // Loaded drive respects the output limit in force when it was computed
    assert property (@(posedge clk) disable iff (!rst_n)
        load_result |=>
            ($signed({drive_reg[WORD_W-1], drive_reg})
                 <= $signed({2'b00, $past(cfg_reg.output_limit)})) &&
            ($signed({drive_reg[WORD_W-1], drive_reg})
                 >= $signed((WORD_W+1)'(0) - {2'b00, $past(cfg_reg.output_limit)})))
        else $error("drive outside output limit");

    // Positional form keeps the integral inside its limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (load_result && (cfg_reg.algorithm_form == FORM_POSITIONAL)) |=>
            ($signed({state_reg.integral_sum[WORD_W-1], state_reg.integral_sum})
                 <= $signed({2'b00, $past(cfg_reg.integral_limit)})) &&
            ($signed({state_reg.integral_sum[WORD_W-1], state_reg.integral_sum})
                 >= $signed((WORD_W+1)'(0) - {2'b00, $past(cfg_reg.integral_limit)})))
        else $error("integral outside integral limit");

    // A stalled sample stays in the input register with the history untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !advance) |=>
            (stage_valid_reg && $stable(setpoint_reg) && $stable(state_reg)))
        else $error("stalled sample or state changed");

endmodule

`default_nettype wire

// File: design/pidpd_datapath.sv
// Combinational control law: error history shift, P/I/D terms and clamps.
`default_nettype none

module pidpd_datapath
(
    input  pidpd_pkg::pidpd_cfg_t                    cfg,
    input  pidpd_pkg::pidpd_state_t                  state,
    input  logic signed [pidpd_pkg::WORD_W-1:0]      setpoint,
    input  logic signed [pidpd_pkg::WORD_W-1:0]      measured,
    output pidpd_pkg::pidpd_state_t                  state_next,
    output logic signed [pidpd_pkg::WORD_W-1:0]      drive
);
    import pidpd_pkg::*;

    logic signed [WORD_W:0]   err_wide;
    logic signed [WORD_W-1:0] err;
    logic signed [WORD_W:0]   d1_wide;
    logic signed [WORD_W+2:0] d2_wide;
    logic signed [WORD_W-1:0] d1;
    logic signed [WORD_W-1:0] d2;
    logic signed [WORD_W-1:0] p_pos;
    logic signed [WORD_W-1:0] i_term;
    logic signed [WORD_W-1:0] p_inc;
    logic signed [WORD_W-1:0] d_inc;
    logic signed [WORD_W:0]   isum_wide;
    logic signed [WORD_W-1:0] isum_pos;
    logic signed [WORD_W:0]   out_pos_wide;
    logic signed [WORD_W+2:0] out_inc_wide;

    always_comb
    begin
        err_wide = {setpoint[WORD_W-1], setpoint} - {measured[WORD_W-1], measured};
        err      = sat_word({{(WIDE_W-WORD_W-1){err_wide[WORD_W]}}, err_wide});

        // Differences against the history as it stands before the shift
        d1_wide = {err[WORD_W-1], err} - {state.error_now[WORD_W-1], state.error_now};
        d1      = sat_word({{(WIDE_W-WORD_W-1){d1_wide[WORD_W]}}, d1_wide});
        d2_wide = {{3{err[WORD_W-1]}}, err}
                - {{2{state.error_now[WORD_W-1]}}, state.error_now, 1'b0}
                + {{3{state.error_last[WORD_W-1]}}, state.error_last};
        d2      = sat_word({{(WIDE_W-WORD_W-3){d2_wide[WORD_W+2]}}, d2_wide});

        i_term = q_mul(cfg.gain_i, err);
        p_pos  = q_mul(cfg.gain_p, err);
        p_inc  = q_mul(cfg.gain_p, d1);
        d_inc  = q_mul(cfg.gain_d, d2);

        // Positional: integrate, clamp integral, add P
        isum_wide    = {state.integral_sum[WORD_W-1], state.integral_sum}
                     + {i_term[WORD_W-1], i_term};
        isum_pos     = clamp_sym(sat_word({{(WIDE_W-WORD_W-1){isum_wide[WORD_W]}}, isum_wide}),
                                 cfg.integral_limit);
        out_pos_wide = {p_pos[WORD_W-1], p_pos} + {isum_pos[WORD_W-1], isum_pos};

        // Incremental: add all increments to the held output
        out_inc_wide = {{3{state.output_held[WORD_W-1]}}, state.output_held}
                     + {{3{p_inc[WORD_W-1]}}, p_inc}
                     + {{3{i_term[WORD_W-1]}}, i_term}
                     + {{3{d_inc[WORD_W-1]}}, d_inc};

        state_next.error_before_last = state.error_last;
        state_next.error_last        = state.error_now;
        state_next.error_now         = err;

        unique case (cfg.algorithm_form)
            FORM_POSITIONAL:
            begin
                state_next.integral_sum = isum_pos;
                drive = clamp_sym(
                    sat_word({{(WIDE_W-WORD_W-1){out_pos_wide[WORD_W]}}, out_pos_wide}),
                    cfg.output_limit);
            end
            FORM_INCREMENTAL:
            begin
                state_next.integral_sum = i_term;
                drive = clamp_sym(
                    sat_word({{(WIDE_W-WORD_W-3){out_inc_wide[WORD_W+2]}}, out_inc_wide}),
                    cfg.output_limit);
            end
            default:
            begin
                state_next.integral_sum = state.integral_sum;
                drive = state.output_held;
            end
        endcase
        state_next.output_held = drive;
    end

endmodule

`default_nettype wire

// File: sim/pid_position_delta_regulator_test.sv
// Self-checking testbench for the PID regulator: directed and random samples against a local predictor.
`default_nettype none

module pid_position_delta_regulator_test;
    import pidpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Quiet cycles tolerated before the run is declared hung. The longest legal gap is
    // the deliberate receiver hold-off plus drain and register writes.
    localparam int unsigned QUIET_LIMIT  = 3000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned RANDOM_RUNS  = 8;
    localparam int unsigned RUN_SAMPLES  = 70;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    localparam logic [WORD_W-1:0] Q_ONE_0   = 32'h0001_0000;
    localparam logic [WORD_W-1:0] Q_QUARTER = 32'h0000_4000;
    localparam logic [WORD_W-1:0] Q_TWO     = 32'h0002_0000;
    localparam logic [WORD_W-1:0] W_MAX     = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] W_MIN     = 32'h8000_0000;

    // Idle mix on both sides of the stream
    typedef enum logic [1:0] {
        PACE_SENDER_LIGHT,
        PACE_RECEIVER_LIGHT,
        PACE_FREE
    } pace_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [2*WORD_W-1:0]       s_tdata   = '0;   // [31:0] setpoint, [63:32] measured
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [WORD_W-1:0]         m_tdata;          // [31:0] drive
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [INDEX_W-1:0]        cfg_index = '0;
    logic [WORD_W-1:0]         cfg_data  = '0;

    pid_position_delta_regulator dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Samples waiting to be offered, and drive values waiting to come back
    logic [2*WORD_W-1:0]       sample_queue[$];
    logic signed [WORD_W-1:0]  drive_expect[$];

    int unsigned send_idle_pct = 6;
    int unsigned recv_idle_pct = 84;
    int unsigned fail_count    = 0;
    int unsigned quiet_cycles  = 0;

    // Receiver hold-off, counted in its own process
    logic        hold_off_req  = 1'b0;
    logic        hold_off_done = 1'b0;
    int unsigned hold_off_left = 0;

    // Register shadow, as the block should hold it
    logic                      reg_form    = FORM_POSITIONAL;
    logic signed [WORD_W-1:0]  reg_gain_p  = '0;
    logic signed [WORD_W-1:0]  reg_gain_i  = '0;
    logic signed [WORD_W-1:0]  reg_gain_d  = '0;
    logic [LIMIT_W-1:0]        reg_out_lim = '0;
    logic [LIMIT_W-1:0]        reg_int_lim = '0;

    // Controller state, as the block should hold it
    logic signed [WORD_W-1:0]  err_now         = '0;
    logic signed [WORD_W-1:0]  err_last        = '0;
    logic signed [WORD_W-1:0]  err_before_last = '0;
    logic signed [WORD_W-1:0]  integ_sum       = '0;
    logic signed [WORD_W-1:0]  held_drive      = '0;

    // Saturate an exact sum or quotient to one signed word
    function automatic logic signed [WORD_W-1:0] to_word(input longint x);
        if (x > WORD_MAX)
        begin
            return W_MAX;
        end
        if (x < WORD_MIN)
        begin
            return W_MIN;
        end
        return x[WORD_W-1:0];
    endfunction

    // Q16.16 product: exact 64-bit product, divide toward zero, saturate
    function automatic logic signed [WORD_W-1:0] fixed_mul(input logic signed [WORD_W-1:0] a,
                                                           input logic signed [WORD_W-1:0] b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return to_word(prod / 64'sd65536);
    endfunction

    function automatic logic signed [WORD_W-1:0] clamp_mag(input logic signed [WORD_W-1:0] x,
                                                           input logic [LIMIT_W-1:0] lim);
        longint hi;
        longint lo;
        hi = longint'(lim);
        lo = -hi;
        if (longint'(x) > hi)
        begin
            return hi[WORD_W-1:0];
        end
        if (longint'(x) < lo)
        begin
            return lo[WORD_W-1:0];
        end
        return x;
    endfunction

    // Advance the controller state by one sample and return the drive it produces
    function automatic logic signed [WORD_W-1:0] regulate(input logic signed [WORD_W-1:0] sp,
                                                          input logic signed [WORD_W-1:0] fb);
        logic signed [WORD_W-1:0] p_term;
        logic signed [WORD_W-1:0] d_term;
        logic signed [WORD_W-1:0] d1;
        logic signed [WORD_W-1:0] d2;
        err_before_last = err_last;
        err_last        = err_now;
        err_now         = to_word(longint'(sp) - longint'(fb));
        if (reg_form == FORM_POSITIONAL)
        begin
            p_term     = fixed_mul(reg_gain_p, err_now);
            integ_sum  = to_word(longint'(integ_sum) + longint'(fixed_mul(reg_gain_i, err_now)));
            integ_sum  = clamp_mag(integ_sum, reg_int_lim);
            held_drive = clamp_mag(to_word(longint'(p_term) + longint'(integ_sum)), reg_out_lim);
        end
        else
        begin
            d1         = to_word(longint'(err_now) - longint'(err_last));
            d2         = to_word(longint'(err_now) - 2 * longint'(err_last)
                                 + longint'(err_before_last));
            p_term     = fixed_mul(reg_gain_p, d1);
            d_term     = fixed_mul(reg_gain_d, d2);
            // Incremental form overwrites the integral; it carries into a later positional run
            integ_sum  = fixed_mul(reg_gain_i, err_now);
            held_drive = to_word(longint'(held_drive) + longint'(p_term)
                                 + longint'(integ_sum) + longint'(d_term));
            held_drive = clamp_mag(held_drive, reg_out_lim);
        end
        return held_drive;
    endfunction

    // Word mix: full range, small and moderate magnitudes, and the corners
    function automatic logic [WORD_W-1:0] rand_word();
        logic [17:0] small_v;
        logic [23:0] mid_v;
        small_v = 18'($urandom);
        mid_v   = 24'($urandom);
        case ($urandom_range(4))
            0: return $urandom;
            1: return {{14{small_v[17]}}, small_v};
            2: return {{8{mid_v[23]}}, mid_v};
            3:
            begin
                case ($urandom_range(4))
                    0: return W_MAX;
                    1: return W_MIN;
                    2: return '0;
                    3: return 32'd1;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return {{14{small_v[17]}}, small_v};
        endcase
    endfunction

    // Limit mix: zero, the largest magnitude, anything, or moderate; bit 31 is ignored
    function automatic logic [WORD_W-1:0] rand_limit();
        case ($urandom_range(3))
            0: return '0;
            1: return W_MAX;
            2: return $urandom;
            default: return $urandom_range(32'h00FF_FFFF);
        endcase
    endfunction

    // Driver: hold the beat until accepted, predict it on acceptance, then offer the next
    always @(posedge clk)
    begin : driver
        logic fire;
        if (rst_n)
        begin
            fire = s_tvalid && s_tready;
            if (fire)
            begin
                drive_expect.push_back(regulate(s_tdata[WORD_W-1:0], s_tdata[2*WORD_W-1:WORD_W]));
            end
            if (!s_tvalid || fire)
            begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= sample_queue.pop_front();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off: start once on request, then count down
    always @(posedge clk)
    begin
        if (hold_off_left != 0)
        begin
            hold_off_left <= hold_off_left - 1;
        end
        else if (hold_off_req && !hold_off_done)
        begin
            hold_off_left <= HOLD_CYCLES;
            hold_off_done <= 1'b1;
        end
    end

    // Monitor: check each drive beat against the oldest prediction, then pick next ready
    always @(posedge clk)
    begin : monitor
        logic signed [WORD_W-1:0] want_drive;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (drive_expect.size() == 0)
                begin
                    $error("drive beat with nothing expected: actual %0d", $signed(m_tdata));
                    fail_count++;
                end
                else
                begin
                    want_drive = drive_expect.pop_front();
                    if (m_tdata !== want_drive)
                    begin
                        $error("drive mismatch: expected %0d, actual %0d",
                               want_drive, $signed(m_tdata));
                        fail_count++;
                    end
                end
            end
            m_tready <= (hold_off_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run if no beat or register write moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_pace(input pace_t pace);
        case (pace)
            PACE_SENDER_LIGHT:
            begin
                send_idle_pct <= 6;
                recv_idle_pct <= 84;
            end
            PACE_RECEIVER_LIGHT:
            begin
                send_idle_pct <= 84;
                recv_idle_pct <= 6;
            end
            default:
            begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
        endcase
    endtask

    // Wait until every queued sample has gone and every drive has returned,
    // then let the pipeline settle
    task automatic settle();
        do
        begin
            @(posedge clk);
        end
        while (sample_queue.size() != 0 || s_tvalid || drive_expect.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // One register write on the config channel; update the shadow on the handshake
    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [WORD_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ALGORITHM_FORM: reg_form    = val[0];
            REG_GAIN_P:         reg_gain_p  = val;
            REG_GAIN_I:         reg_gain_i  = val;
            REG_GAIN_D:         reg_gain_d  = val;
            REG_OUTPUT_LIMIT:   reg_out_lim = val[LIMIT_W-1:0];
            REG_INTEGRAL_LIMIT: reg_int_lim = val[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    // Drain, then write all six registers
    task automatic program_regs(input logic form, input logic [WORD_W-1:0] gp,
                                input logic [WORD_W-1:0] gi, input logic [WORD_W-1:0] gd,
                                input logic [WORD_W-1:0] olim, input logic [WORD_W-1:0] ilim);
        settle();
        write_reg(REG_ALGORITHM_FORM, {31'd0, form});
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_OUTPUT_LIMIT, olim);
        write_reg(REG_INTEGRAL_LIMIT, ilim);
    endtask

    task automatic add_sample(input logic [WORD_W-1:0] sp, input logic [WORD_W-1:0] fb);
        sample_queue.push_back({fb, sp});
    endtask

    initial
    begin : sequencer
        int unsigned      run;
        int unsigned      k;
        logic [WORD_W-1:0] base;
        logic [WORD_W-1:0] noise;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_pace(PACE_SENDER_LIGHT);

        // Positional: unit P, quarter I, derivative gain set but unused
        program_regs(FORM_POSITIONAL, Q_ONE_0, Q_QUARTER, W_MAX, 32'h0064_0000, 32'h000A_0000);
        add_sample('0, '0);
        add_sample(Q_ONE_0, '0);
        // Tiny negative error: the integral product must round toward zero, not down
        add_sample('0, 32'd1);
        // Error saturates high, integral and drive hit their clamps
        add_sample(W_MAX, W_MIN);
        add_sample(W_MIN, W_MAX);
        add_sample(W_MIN, W_MIN);
        add_sample(W_MAX, W_MAX);

        // Incremental with extreme gains: products and both differences saturate on the extreme samples
        program_regs(FORM_INCREMENTAL, W_MAX, W_MIN, W_MIN, W_MAX, W_MAX);
        add_sample(W_MAX, W_MIN);
        add_sample(W_MIN, W_MAX);
        add_sample(W_MAX, W_MIN);
        add_sample('0, '0);
        add_sample(32'h0001_2345, 32'hFFFA_BCDF);

        // Zero limits pin the integral and the drive to zero
        program_regs(FORM_POSITIONAL, Q_ONE_0, Q_ONE_0, Q_ONE_0, '0, '0);
        add_sample(32'h0010_0000, '0);
        add_sample(W_MIN, 32'h0000_0001);
        add_sample(W_MAX, W_MIN);

        // Incremental leaves its integral and held drive behind for the positional run
        program_regs(FORM_INCREMENTAL, Q_QUARTER, Q_TWO, Q_QUARTER, W_MAX, W_MAX);
        add_sample(32'h0003_0000, '0);
        add_sample(32'h0005_8000, 32'h0001_0000);
        settle();
        write_reg(REG_ALGORITHM_FORM, {31'd0, FORM_POSITIONAL});
        add_sample(32'h0002_0000, 32'h0001_0000);
        add_sample('0, 32'h0000_8000);

        // Random runs: fresh registers each time, mostly tracking a setpoint with noise
        for (run = 0; run < RANDOM_RUNS; run++)
        begin
            if (run < 3)
            begin
                set_pace(PACE_SENDER_LIGHT);
            end
            else if (run < 6)
            begin
                set_pace(PACE_RECEIVER_LIGHT);
            end
            else
            begin
                set_pace(PACE_FREE);
            end
            program_regs(1'($urandom_range(1)), rand_word(), rand_word(), rand_word(),
                         rand_limit(), rand_limit());
            base = rand_word();
            for (k = 0; k < RUN_SAMPLES; k++)
            begin
                noise = {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
                if ($urandom_range(15) == 0)
                begin
                    base = rand_word();
                end
                if ($urandom_range(9) < 7)
                begin
                    add_sample(base, base + noise);
                end
                else
                begin
                    add_sample(rand_word(), rand_word());
                end
            end
            // Stall the receiver while the sender keeps offering: fill the block
            if (run == 6)
            begin
                hold_off_req <= 1'b1;
            end
        end

        settle();
        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
